[rtl/tli_pkg.sv]
// Shared types, constants and control structs of the table linear interpolator.
package tli_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int DATA_WIDTH          = 32;
   localparam int INDEX_WIDTH         = 8;
   localparam int CFG_WIDTH           = 9;
   localparam int MIN_ENTRIES         = 2;
   localparam logic [CFG_WIDTH-1:0] TABLE_SIZE_RESET = 9'd2;

   // Signed differences and their magnitudes
   localparam int DIFF_WIDTH = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH + 1;
   // Quotients at or above 2^QUOT_WIDTH saturate before division starts
   localparam int QUOT_WIDTH       = 34;
   localparam int DIV_STEPS        = QUOT_WIDTH;
   localparam int DIV_COUNT_WIDTH  = 6;
   localparam int QRND_WIDTH       = QUOT_WIDTH + 1;
   localparam int SUM_WIDTH        = QRND_WIDTH + 1;
   localparam logic [QRND_WIDTH-1:0] SUM_LIMIT = 35'h2_0000_0000;

   localparam logic signed [DATA_WIDTH-1:0] Y_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] Y_MIN = 32'sh8000_0000;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_FIRST,
      ST_READ_LAST,
      ST_DIRECTION,
      ST_PROBE,
      ST_COMPARE,
      ST_FETCH_LOW,
      ST_FETCH_HIGH,
      ST_CAPTURE,
      ST_MULTIPLY,
      ST_DIV_SETUP,
      ST_DIVIDE,
      ST_ROUND,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RD_FIRST,
      RD_LAST,
      RD_MID,
      RD_LOW,
      RD_HIGH
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       start;
      rd_sel_type rd_sel;
      logic       cap_first;
      logic       cap_dir;
      logic       cmp_mid;
      logic       cap_low;
      logic       cap_high;
      logic       mult;
      logic       div_init;
      logic       div_step;
      logic       round;
      logic       sum;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic size_error;
      logic span_gt1;
      logic div_done;
   } status_type;

endpackage

[rtl/tli_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tli_datapath.sv]
// Datapath: table memories, bisection registers, multiplier, serial divider, result register.
module tli_datapath #(
   parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tli_pkg::cmd_type                        cmd,
   output tli_pkg::status_type                     status,
   input  logic                                    csr_valid,
   input  logic [tli_pkg::CFG_WIDTH-1:0]           csr_table_size,
   input  logic [tli_pkg::INDEX_WIDTH-1:0]         req_entry_index,
   input  logic signed [tli_pkg::DATA_WIDTH-1:0]   req_entry_x,
   input  logic signed [tli_pkg::DATA_WIDTH-1:0]   req_entry_y,
   input  logic signed [tli_pkg::DATA_WIDTH-1:0]   req_query_x,
   output logic signed [tli_pkg::DATA_WIDTH-1:0]   rsp_interp_y,
   output logic                                    rsp_size_error,
   output logic                                    rsp_saturated
);
   import tli_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = (AW + 1 > CFG_WIDTH) ? AW + 1 : CFG_WIDTH;

   // Configuration
   logic [CFG_WIDTH-1:0] table_size_ff;

   // Search state
   logic signed [DATA_WIDTH-1:0] query_x_ff, query_x_in;
   logic                         size_err_ff, size_err_in;
   logic [AW-1:0]                low_ff, low_in, up_ff, up_in;
   logic signed [DATA_WIDTH-1:0] x_first_ff, x_first_in;
   logic                         ascend_ff, ascend_in;
   logic signed [DATA_WIDTH-1:0] x0_ff, x0_in, y0_ff, y0_in;

   // Arithmetic
   logic signed [DIFF_WIDTH-1:0] num_ff, num_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [PROD_WIDTH-1:0]        prod_ff, prod_in;
   logic [DIFF_WIDTH-1:0]        dxm_ff, dxm_in;
   logic                         neg_sign_ff, neg_sign_in;
   logic                         dx_zero_ff, dx_zero_in;
   logic                         sat_big_ff, sat_big_in;
   logic [DIFF_WIDTH-1:0]        div_rem_ff, div_rem_in;
   logic [QUOT_WIDTH-1:0]        div_bits_ff, div_bits_in;
   logic [DIV_COUNT_WIDTH-1:0]   div_count_ff, div_count_in;
   logic [QRND_WIDTH-1:0]        q_rnd_ff, q_rnd_in;
   logic                         big_ff, big_in;
   logic signed [DATA_WIDTH-1:0] res_y_ff, res_y_in;
   logic                         res_sat_ff, res_sat_in;

   // Output register
   logic signed [DATA_WIDTH-1:0] out_y_ff, out_y_in;
   logic                         out_err_ff, out_err_in, out_sat_ff, out_sat_in;

   // Memory ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] rd_x, rd_y;

   // Combinational helpers
   logic [SW-1:0]              size_ext, limit;
   logic [AW-1:0]              last_idx, mid_idx;
   logic [AW:0]                mid_sum;
   logic [DIFF_WIDTH-1:0]      mag_num, mag_dy, mag_dx;
   logic [2*DATA_WIDTH-1:0]    mul_mag;
   logic [PROD_WIDTH-1:0]      prod_calc;
   logic [QUOT_WIDTH-1:0]      trial;
   logic                       trial_ge;
   logic                       round_up;
   logic                       neg_res;
   logic [SUM_WIDTH-1:0]       q_ext;
   logic signed [SUM_WIDTH-1:0] sum_val;

   function automatic logic [DIFF_WIDTH-1:0] magnitude(input logic signed [DIFF_WIDTH-1:0] v);
      return v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_valid) begin
         table_size_ff <= csr_table_size;
      end
   end

   tli_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TABLE_DEPTH)) u_x_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_entry_x),
      .rd_addr (rd_addr),
      .rd_data (rd_x)
   );

   tli_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TABLE_DEPTH)) u_y_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_entry_y),
      .rd_addr (rd_addr),
      .rd_data (rd_y)
   );

   // Drop loads beyond the table depth
   assign wr_en   = cmd.load && (32'(req_entry_index) < TABLE_DEPTH);
   assign wr_addr = AW'(req_entry_index);

   // Entries in use, clipped to the depth
   assign size_ext = SW'(table_size_ff);
   assign limit    = (size_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : size_ext;
   assign last_idx = AW'(limit - SW'(1));

   assign mid_sum = {1'b0, up_ff} + {1'b0, low_ff};
   assign mid_idx = mid_sum[AW:1];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = up_ff;
         RD_MID:   rd_addr = mid_idx;
         RD_LOW:   rd_addr = low_ff;
         RD_HIGH:  rd_addr = low_ff + AW'(1);
         default:  rd_addr = '0;
      endcase
   end

   assign status.size_error = table_size_ff < CFG_WIDTH'(MIN_ENTRIES);
   assign status.span_gt1   = (up_ff - low_ff) > AW'(1);
   assign status.div_done   = div_count_ff == '0;

   // A magnitude of 2^32 has no other bits set, so the product is a shift
   assign mag_num = magnitude(num_ff);
   assign mag_dy  = magnitude(dy_ff);
   assign mag_dx  = magnitude(dx_ff);
   assign mul_mag = mag_num[DATA_WIDTH-1:0] * mag_dy[DATA_WIDTH-1:0];
   always_comb begin
      if (mag_num[DIFF_WIDTH-1]) begin
         prod_calc = {mag_dy, {DATA_WIDTH{1'b0}}};
      end else if (mag_dy[DIFF_WIDTH-1]) begin
         prod_calc = {mag_num, {DATA_WIDTH{1'b0}}};
      end else begin
         prod_calc = {1'b0, mul_mag};
      end
   end

   // Restoring divide step: one quotient bit per cycle
   assign trial    = {div_rem_ff, div_bits_ff[QUOT_WIDTH-1]};
   assign trial_ge = trial >= {1'b0, dxm_ff};
   assign round_up = {div_rem_ff, 1'b0} >= {1'b0, dxm_ff};

   assign neg_res = neg_sign_ff && (q_rnd_ff != '0);
   assign q_ext   = {1'b0, q_rnd_ff};
   assign sum_val = $signed({{(SUM_WIDTH-DATA_WIDTH){y0_ff[DATA_WIDTH-1]}}, y0_ff})
                    + $signed(neg_res ? (~q_ext + SUM_WIDTH'(1)) : q_ext);

   always_comb begin
      query_x_in   = query_x_ff;
      size_err_in  = size_err_ff;
      low_in       = low_ff;
      up_in        = up_ff;
      x_first_in   = x_first_ff;
      ascend_in    = ascend_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      num_in       = num_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      dxm_in       = dxm_ff;
      neg_sign_in  = neg_sign_ff;
      dx_zero_in   = dx_zero_ff;
      sat_big_in   = sat_big_ff;
      div_rem_in   = div_rem_ff;
      div_bits_in  = div_bits_ff;
      div_count_in = div_count_ff;
      q_rnd_in     = q_rnd_ff;
      big_in       = big_ff;
      res_y_in     = res_y_ff;
      res_sat_in   = res_sat_ff;
      out_y_in     = out_y_ff;
      out_err_in   = out_err_ff;
      out_sat_in   = out_sat_ff;

      if (cmd.start) begin
         query_x_in  = req_query_x;
         size_err_in = status.size_error;
         low_in      = '0;
         up_in       = last_idx;
      end
      if (cmd.cap_first) begin
         x_first_in = $signed(rd_x);
      end
      if (cmd.cap_dir) begin
         ascend_in = $signed(rd_x) >= x_first_ff;
      end
      if (cmd.cmp_mid) begin
         if ((query_x_ff >= $signed(rd_x)) == ascend_ff) begin
            low_in = mid_idx;
         end else begin
            up_in = mid_idx;
         end
      end
      if (cmd.cap_low) begin
         x0_in = $signed(rd_x);
         y0_in = $signed(rd_y);
      end
      if (cmd.cap_high) begin
         num_in = DIFF_WIDTH'(query_x_ff) - DIFF_WIDTH'(x0_ff);
         dx_in  = DIFF_WIDTH'($signed(rd_x)) - DIFF_WIDTH'(x0_ff);
         dy_in  = DIFF_WIDTH'($signed(rd_y)) - DIFF_WIDTH'(y0_ff);
      end
      if (cmd.mult) begin
         prod_in     = prod_calc;
         dxm_in      = mag_dx;
         neg_sign_in = num_ff[DIFF_WIDTH-1] ^ dy_ff[DIFF_WIDTH-1];
         dx_zero_in  = dx_ff == '0;
      end
      if (cmd.div_init) begin
         sat_big_in   = {2'b00, prod_ff} >= {dxm_ff, {QUOT_WIDTH{1'b0}}};
         div_rem_in   = DIFF_WIDTH'(prod_ff[PROD_WIDTH-1:QUOT_WIDTH]);
         div_bits_in  = prod_ff[QUOT_WIDTH-1:0];
         div_count_in = DIV_COUNT_WIDTH'(DIV_STEPS - 1);
      end
      if (cmd.div_step) begin
         div_rem_in   = trial_ge ? DIFF_WIDTH'(trial - QUOT_WIDTH'(dxm_ff))
                                 : DIFF_WIDTH'(trial);
         div_bits_in  = {div_bits_ff[QUOT_WIDTH-2:0], trial_ge};
         div_count_in = div_count_ff - DIV_COUNT_WIDTH'(1);
      end
      if (cmd.round) begin
         q_rnd_in = {1'b0, div_bits_ff} + QRND_WIDTH'(round_up);
         big_in   = sat_big_ff || ({1'b0, div_bits_ff} + QRND_WIDTH'(round_up) > SUM_LIMIT);
      end
      if (cmd.sum) begin
         if (dx_zero_ff) begin
            res_y_in   = y0_ff;
            res_sat_in = 1'b0;
         end else if (big_ff) begin
            res_y_in   = neg_sign_ff ? Y_MIN : Y_MAX;
            res_sat_in = 1'b1;
         end else if (sum_val > $signed(SUM_WIDTH'(Y_MAX))) begin
            res_y_in   = Y_MAX;
            res_sat_in = 1'b1;
         end else if (sum_val < SUM_WIDTH'(Y_MIN)) begin
            res_y_in   = Y_MIN;
            res_sat_in = 1'b1;
         end else begin
            res_y_in   = DATA_WIDTH'(sum_val);
            res_sat_in = 1'b0;
         end
      end
      if (cmd.out_load) begin
         out_y_in   = size_err_ff ? '0 : res_y_ff;
         out_err_in = size_err_ff;
         out_sat_in = size_err_ff ? 1'b0 : res_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      query_x_ff   <= query_x_in;
      size_err_ff  <= size_err_in;
      low_ff       <= low_in;
      up_ff        <= up_in;
      x_first_ff   <= x_first_in;
      ascend_ff    <= ascend_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      num_ff       <= num_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      prod_ff      <= prod_in;
      dxm_ff       <= dxm_in;
      neg_sign_ff  <= neg_sign_in;
      dx_zero_ff   <= dx_zero_in;
      sat_big_ff   <= sat_big_in;
      div_rem_ff   <= div_rem_in;
      div_bits_ff  <= div_bits_in;
      div_count_ff <= div_count_in;
      q_rnd_ff     <= q_rnd_in;
      big_ff       <= big_in;
      res_y_ff     <= res_y_in;
      res_sat_ff   <= res_sat_in;
      out_y_ff     <= out_y_in;
      out_err_ff   <= out_err_in;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_interp_y   = out_y_ff;
   assign rsp_size_error = out_err_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

[rtl/tli_ctrl.sv]
// Controller: sequences load, bisection, multiply, divide and result transfer.
module tli_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tli_pkg::status_type status,
   output tli_pkg::cmd_type    cmd
);
   import tli_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      is_query;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_query = req_type == REQ_QUERY;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && is_query) begin
               state_in = status.size_error ? ST_FINISH : ST_READ_FIRST;
            end
         end
         ST_READ_FIRST: state_in = ST_READ_LAST;
         ST_READ_LAST:  state_in = ST_DIRECTION;
         ST_DIRECTION:  state_in = ST_PROBE;
         ST_PROBE:      state_in = status.span_gt1 ? ST_COMPARE : ST_FETCH_LOW;
         ST_COMPARE:    state_in = ST_PROBE;
         ST_FETCH_LOW:  state_in = ST_FETCH_HIGH;
         ST_FETCH_HIGH: state_in = ST_CAPTURE;
         ST_CAPTURE:    state_in = ST_MULTIPLY;
         ST_MULTIPLY:   state_in = ST_DIV_SETUP;
         ST_DIV_SETUP:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND:      state_in = ST_SUM;
         ST_SUM:        state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_FIRST;
      cmd.load     = (state_ff == ST_IDLE) && req_valid && !is_query;
      cmd.start    = (state_ff == ST_IDLE) && req_valid && is_query;
      unique case (state_ff)
         ST_READ_FIRST: cmd.rd_sel = RD_FIRST;
         ST_READ_LAST: begin
            cmd.rd_sel    = RD_LAST;
            cmd.cap_first = 1'b1;
         end
         ST_DIRECTION:  cmd.cap_dir = 1'b1;
         ST_PROBE:      cmd.rd_sel = RD_MID;
         ST_COMPARE:    cmd.cmp_mid = 1'b1;
         ST_FETCH_LOW:  cmd.rd_sel = RD_LOW;
         ST_FETCH_HIGH: begin
            cmd.rd_sel  = RD_HIGH;
            cmd.cap_low = 1'b1;
         end
         ST_CAPTURE:    cmd.cap_high = 1'b1;
         ST_MULTIPLY:   cmd.mult = 1'b1;
         ST_DIV_SETUP:  cmd.div_init = 1'b1;
         ST_DIVIDE:     cmd.div_step = 1'b1;
         ST_ROUND:      cmd.round = 1'b1;
         ST_SUM:        cmd.sum = 1'b1;
         ST_FINISH:     cmd.out_load = out_free;
         default:       cmd.rd_sel = RD_FIRST;
      endcase
   end

   // Hold the result until its transfer, then drop valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/table_linear_interpolator_top.sv]
// Top level of the table linear interpolator: controller, datapath and checks.
//
// Request channel (req_valid / req_stall): a load item (req_type = 0) writes
// entry req_entry_index of the x and y tables; one load is taken per cycle
// while the block is idle, and loads at or beyond the depth are dropped.
// A query item (req_type = 1) bisects the x column and interpolates at
// req_query_x over the bracketing pair, extrapolating past the ends.
// Response channel (rsp_valid / rsp_stall): one transfer per query.
// A query takes k bisection probes, k <= 8 for 256 entries in use; the
// 34-step serial divider and the one read port of the x table set its
// latency. The next item is taken in the cycle rsp_valid rises. A query
// with fewer than two entries in use goes straight to the finish state and
// answers with size_error.
// The result sits in an output register: a stalled response holds there and
// the block keeps taking loads; a finished query waits for that register.
// csr_valid / csr_ready writes table_size, always ready; write it only while idle.
// Reset clears the control state and sets table_size to 2; table contents
// are undefined until loaded.
module table_linear_interpolator_top #(
   parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [tli_pkg::INDEX_WIDTH-1:0]       req_entry_index,
   input  logic signed [tli_pkg::DATA_WIDTH-1:0] req_entry_x,
   input  logic signed [tli_pkg::DATA_WIDTH-1:0] req_entry_y,
   input  logic signed [tli_pkg::DATA_WIDTH-1:0] req_query_x,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [tli_pkg::DATA_WIDTH-1:0] rsp_interp_y,
   output logic                                  rsp_size_error,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tli_pkg::CFG_WIDTH-1:0]         csr_table_size
);
   import tli_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid && csr_ready),
      .csr_table_size  (csr_table_size),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .rsp_interp_y    (rsp_interp_y),
      .rsp_size_error  (rsp_size_error),
      .rsp_saturated   (rsp_saturated)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_query : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && (req_type == REQ_QUERY)))
      else $error("request stall rose without an accepted query");

   a_result_from_query : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a query in progress");

   a_size_error_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_error |-> (rsp_interp_y == '0) && !rsp_saturated)
      else $error("size error response carries a value");

   a_saturated_extreme : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_interp_y == Y_MAX) || (rsp_interp_y == Y_MIN))
      else $error("saturated response is not at a range limit");
`endif

endmodule
